/* design/wfdf_pkg.sv */
// Shared types and constants for the frame delta filter.
package wfdf_pkg;

   localparam int BYTE_W   = 8;
   localparam int STRIDE_W = 6;
   localparam int END_W    = 32;
   localparam int LEFT_W   = 3;
   localparam int CSR_IDX_W = 2;

   // ASCII 'data' as it sits in the shift window after the last tag byte
   localparam logic [END_W-1:0]  DATA_TAG  = 32'h6461_7461;
   localparam logic [LEFT_W-1:0] LEN_BYTES = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_BYTES      = 2'd0,
      CSR_DECODE_MODE      = 2'd1,
      CSR_START_SEEKING    = 2'd2,
      CSR_INITIAL_DATA_END = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             seek_we;
      logic             seek_val;
      logic             end_we;
      logic [END_W-1:0] end_val;
   } seek_cfg_type;

   typedef struct packed {
      logic             active;
      logic             fail;
      logic             seeking_after;
      logic [END_W-1:0] end_after;
   } seek_status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              seeking;
      logic [END_W-1:0]  data_end;
      logic              seek_failed;
   } rsp_item_type;

endpackage

/* design/wfdf_cell.sv */
// One history cell: holds one prior byte and the frame position token.
module wfdf_cell
   import wfdf_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,   // delta-phase item taken
   input  logic                clear_pos, // position back to cell 0
   input  logic [STRIDE_W-1:0] stride,    // effective stride
   input  logic                tok_left,  // token offered by left neighbor
   input  logic [BYTE_W-1:0]   org_byte,
   output logic [BYTE_W-1:0]   sel_byte,
   output logic                tok_q,
   output logic                pass,
   output logic                wrap
);

   localparam logic [STRIDE_W:0] NEXT_POS = (STRIDE_W + 1)'(INDEX + 1);

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              tok_ff, tok_in;
   logic              has_next;

   assign has_next = {1'b0, stride} > NEXT_POS;
   assign pass     = tok_ff & has_next;
   assign wrap     = tok_ff & ~has_next;
   assign sel_byte = tok_ff ? byte_ff : '0;
   assign tok_q    = tok_ff;

   always_comb begin
      byte_in = byte_ff;
      tok_in  = tok_ff;
      if (clear_pos) begin
         tok_in = (INDEX == 0);
      end else if (advance) begin
         tok_in = tok_left;
         if (tok_ff) begin
            byte_in = org_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         tok_ff  <= (INDEX == 0);
      end else begin
         byte_ff <= byte_in;
         tok_ff  <= tok_in;
      end
   end

endmodule

/* design/wfdf_seek.sv */
// Tag search and length capture for the seek phase.
module wfdf_seek
   import wfdf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] in_byte,
   input  seek_cfg_type      cfg,
   output seek_status_type   status
);

   logic [END_W-1:0]  win_ff, win_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              active_ff, active_in;
   logic [END_W-1:0]  end_ff, end_in;

   logic [END_W-1:0]  win_shift;
   logic [END_W-1:0]  len;
   logic              last;
   logic              fail;

   assign win_shift = {win_ff[END_W-BYTE_W-1:0], in_byte};
   // little-endian length: first captured byte is least significant
   assign len  = {win_shift[7:0], win_shift[15:8], win_shift[23:16], win_shift[31:24]};
   assign last = (left_ff == LEFT_W'(1));
   assign fail = active_ff & last & ~($signed(end_ff) > $signed(len));

   always_comb begin
      win_in    = win_ff;
      left_in   = left_ff;
      active_in = active_ff;
      end_in    = end_ff;
      if (step && active_ff) begin
         win_in = win_shift;
         if (left_ff != '0) begin
            left_in = left_ff - LEFT_W'(1);
            if (last) begin
               active_in = 1'b0;
               if (fail) begin
                  end_in = '0;
                  win_in = '0;
               end else begin
                  end_in = len;
               end
            end
         end else if (win_shift == DATA_TAG) begin
            left_in = LEN_BYTES;
         end
      end
      if (cfg.seek_we) begin
         active_in = cfg.seek_val;
      end
      if (cfg.end_we) begin
         end_in = cfg.end_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         left_ff   <= '0;
         active_ff <= 1'b0;
         end_ff    <= '0;
      end else begin
         win_ff    <= win_in;
         left_ff   <= left_in;
         active_ff <= active_in;
         end_ff    <= end_in;
      end
   end

   assign status.active        = active_ff;
   assign status.fail          = step & fail;
   assign status.seeking_after = active_in;
   assign status.end_after     = end_in;

endmodule

/* design/wav_frame_delta_filter_core.sv */
// Top level of the frame delta filter: seek unit, cell row and output buffer.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_in_byte
//   rsp      out  rsp_valid/rsp_ready    rsp_out_byte, rsp_seeking, rsp_data_end,
//                                        rsp_seek_failed
//   csr      in   csr_write_en           csr_index, csr_wdata
//
// One item per cycle while req_ready is high. An item's result is computed
// in the cycle it is taken (one add/subtract on the byte selected by the
// position token, or the 32-bit length compare) and is registered into a
// two-entry output buffer, whose head is shown. req_ready drops only while
// both buffer entries are full. Synchronous reset clears the history bytes,
// puts the token on cell 0 and resets control state, not the buffer entries.
module wav_frame_delta_filter_core
   import wfdf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BYTE_W-1:0]          rsp_out_byte,
   output logic                       rsp_seeking,
   output logic signed [END_W-1:0]    rsp_data_end,
   output logic                       rsp_seek_failed,
   input  logic                       csr_write_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [END_W-1:0]           csr_wdata
);

   // ---------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic                decode_ff, decode_in;
   logic                wr_stride;
   seek_cfg_type        seek_cfg;
   seek_status_type     seek_st;

   assign wr_stride = csr_write_en && (csr_index == CSR_FRAME_BYTES);

   assign seek_cfg.seek_we  = csr_write_en && (csr_index == CSR_START_SEEKING);
   assign seek_cfg.seek_val = csr_wdata[0];
   assign seek_cfg.end_we   = csr_write_en && (csr_index == CSR_INITIAL_DATA_END);
   assign seek_cfg.end_val  = csr_wdata;

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   logic       delta_step;

   assign req_ready  = (cnt_ff != 2'd2);
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign push       = req_valid & req_ready;
   assign pop        = rsp_valid & rsp_ready;
   assign delta_step = push & ~seek_st.active;

   // failure drops the stride to zero and sends the token home
   always_comb begin
      stride_in = stride_ff;
      decode_in = decode_ff;
      if (wr_stride) begin
         stride_in = csr_wdata[STRIDE_W-1:0];
      end else if (seek_st.fail) begin
         stride_in = '0;
      end
      if (csr_write_en && (csr_index == CSR_DECODE_MODE)) begin
         decode_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_W'(1);
         decode_ff <= 1'b0;
      end else begin
         stride_ff <= stride_in;
         decode_ff <= decode_in;
      end
   end

   // zero acts as one; above the cell count clamps to the cell count
   logic [STRIDE_W-1:0] stride_eff;
   always_comb begin
      if (stride_ff == '0) begin
         stride_eff = STRIDE_W'(1);
      end else if ({1'b0, stride_ff} > (STRIDE_W + 1)'(MAX_FRAME_BYTES)) begin
         stride_eff = STRIDE_W'(MAX_FRAME_BYTES);
      end else begin
         stride_eff = stride_ff;
      end
   end

   // ---------------------------------------------------------------
   // seek unit
   // ---------------------------------------------------------------
   wfdf_seek u_seek (
      .clock   (clock),
      .reset   (reset),
      .step    (push),
      .in_byte (req_in_byte),
      .cfg     (seek_cfg),
      .status  (seek_st)
   );

   // ---------------------------------------------------------------
   // cell row: cell k holds history byte k; the one-hot token marks the
   // current frame position and moves one cell right per delta item,
   // wrapping to cell 0 at the end of the frame.
   // ---------------------------------------------------------------
   logic [MAX_FRAME_BYTES-1:0] tok_q, pass_q, wrap_q;
   logic [BYTE_W-1:0]          sel_q [MAX_FRAME_BYTES];
   logic                       wrap_any;
   logic [BYTE_W-1:0]          prev_byte;
   logic [BYTE_W-1:0]          org_byte;
   logic [BYTE_W-1:0]          delta_byte;
   logic                       clear_pos;

   assign wrap_any  = |wrap_q;
   assign clear_pos = wr_stride | seek_st.fail;

   for (genvar k = 0; k < MAX_FRAME_BYTES; k++) begin : g_cell
      wfdf_cell #(
         .INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (delta_step),
         .clear_pos (clear_pos),
         .stride    (stride_eff),
         .tok_left  ((k == 0) ? wrap_any : pass_q[(k + MAX_FRAME_BYTES - 1) % MAX_FRAME_BYTES]),
         .org_byte  (org_byte),
         .sel_byte  (sel_q[k]),
         .tok_q     (tok_q[k]),
         .pass      (pass_q[k]),
         .wrap      (wrap_q[k])
      );
   end

   always_comb begin
      prev_byte = '0;
      for (int k = 0; k < MAX_FRAME_BYTES; k++) begin
         prev_byte = prev_byte | sel_q[k];
      end
   end

   // decode stores the rebuilt byte, encode stores the raw byte
   assign org_byte   = decode_ff ? (req_in_byte + prev_byte) : req_in_byte;
   assign delta_byte = decode_ff ? org_byte : (req_in_byte - prev_byte);

   rsp_item_type new_item;
   assign new_item.out_byte    = seek_st.active ? req_in_byte : delta_byte;
   assign new_item.seeking     = seek_st.seeking_after;
   assign new_item.data_end    = seek_st.end_after;
   assign new_item.seek_failed = seek_st.fail;

   // ---------------------------------------------------------------
   // two-entry output buffer: head is shown, the second entry catches an
   // item taken while the head is stalled
   // ---------------------------------------------------------------
   rsp_item_type head_ff, head_in, tail_ff, tail_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = new_item;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = new_item;
            end else if (push) begin
               tail_in = new_item;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_out_byte    = head_ff.out_byte;
   assign rsp_seeking     = head_ff.seeking;
   assign rsp_data_end    = head_ff.data_end;
   assign rsp_seek_failed = head_ff.seek_failed;

`ifndef NO_ASSERTIONS
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(tok_q))
      else $error("frame position token not one-hot");

   a_fail_home: assert property (@(posedge clock) disable iff (reset)
      seek_st.fail |=> tok_q[0] && (stride_ff == '0))
      else $error("failure did not reset position and stride");

   a_fail_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seek_failed |-> !rsp_seeking && (rsp_data_end == '0))
      else $error("failed item carries seek state");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !$past(reset))
      else $error("input stalled with no item held");

   a_fail_in_seek: assert property (@(posedge clock) disable iff (reset)
      seek_st.fail |-> push && seek_st.active && !seek_st.seeking_after)
      else $error("failure outside seek phase");
`endif

endmodule

/* verif/tb_wav_frame_delta_filter_core.sv */
// Self-checking testbench for the frame delta filter core: directed and random byte streams.
module tb_wav_frame_delta_filter_core;
   import wfdf_pkg::*;

   localparam int FRAME_CAP   = 32;       // history depth given to the block
   localparam int POS_W       = $clog2(FRAME_CAP);
   localparam int IDLE_MAX    = 14;       // longest idle burst on either side
   localparam int PHASES      = 40;       // random phases
   localparam int QUIET_PHASE = 35;       // from here on both sides run flat out
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 100;

   // ---------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ---------------------------------------------------------------------------
   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_in_byte  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready    = 1'b0;
   logic [BYTE_W-1:0]       rsp_out_byte;
   logic                    rsp_seeking;
   logic signed [END_W-1:0] rsp_data_end;
   logic                    rsp_seek_failed;
   logic                    csr_write_en = 1'b0;
   csr_index_type           csr_index    = CSR_FRAME_BYTES;
   logic [END_W-1:0]        csr_wdata    = '0;

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the filter's registers and history
   // ---------------------------------------------------------------------------
   logic [BYTE_W-1:0]       hist_q [FRAME_CAP];   // byte one frame back, per slot
   logic [POS_W-1:0]        pos_q;                // slot of the next delta byte
   logic [STRIDE_W-1:0]     stride_q;             // live stride, may be 0 or oversized
   logic [END_W-1:0]        window_q;             // last four seek bytes
   logic [LEFT_W-1:0]       left_q;               // length bytes still to capture
   logic                    seek_q;
   logic signed [END_W-1:0] end_q;
   logic [STRIDE_W-1:0]     cfg_frame_bytes;
   logic                    cfg_decode;
   logic                    cfg_start_seek;
   logic signed [END_W-1:0] cfg_initial_end;

   // stimulus and scoreboard
   logic [BYTE_W-1:0]       byte_feed_q [$];      // items waiting for the driver
   rsp_item_type            coded_rsp_q [$];      // predicted results, oldest first
   rsp_item_type            head_rsp;
   int                      bytes_queued   = 0;
   int                      results_seen   = 0;
   int                      mismatch_count = 0;
   int                      cycle_count    = 0;
   int                      send_idle_pct  = 0;
   int                      recv_idle_pct  = 0;
   int                      send_gap       = 0;
   int                      recv_stall     = 0;

   wav_frame_delta_filter_core #(
      .MAX_FRAME_BYTES (FRAME_CAP)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_seeking     (rsp_seeking),
      .rsp_data_end    (rsp_data_end),
      .rsp_seek_failed (rsp_seek_failed),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: one byte in, one result out, state updated in place
   // ---------------------------------------------------------------------------
   function automatic rsp_item_type filter_byte(input logic [BYTE_W-1:0] b);
      rsp_item_type      r;
      int unsigned       span;
      int unsigned       slot;
      logic [BYTE_W-1:0] prev;
      logic [BYTE_W-1:0] orig;
      logic [END_W-1:0]  len;
      logic              failed;
      failed = 1'b0;
      if (seek_q) begin
         // seek phase: byte passes through and only feeds the tag window
         r.out_byte = b;
         window_q = {window_q[END_W-BYTE_W-1:0], b};
         if (left_q != '0) begin
            // a tag pattern inside the length bytes does not re-arm the capture
            left_q = left_q - LEFT_W'(1);
            if (left_q == '0) begin
               len = {window_q[7:0], window_q[15:8], window_q[23:16], window_q[31:24]};
               if (end_q > $signed(len)) begin
                  end_q = len;
               end else begin
                  // length not below data end: wipe end, stride, position and window
                  failed   = 1'b1;
                  end_q    = '0;
                  stride_q = '0;
                  pos_q    = '0;
                  window_q = '0;
               end
               seek_q = 1'b0;
            end
         end else if (window_q == DATA_TAG) begin
            left_q = LEN_BYTES;
         end
      end else begin
         // delta phase; zero stride means 1, oversized stride is clamped
         span = (stride_q == '0) ? 1 : int'(stride_q);
         if (span > FRAME_CAP) span = FRAME_CAP;
         slot = 32'(pos_q);
         if (slot >= span) slot = 0;
         prev = hist_q[POS_W'(slot)];
         if (cfg_decode) begin
            orig       = b + prev;
            r.out_byte = orig;
         end else begin
            orig       = b;
            r.out_byte = b - prev;
         end
         hist_q[POS_W'(slot)] = orig;       // history always holds the raw stream byte
         slot++;
         if (slot >= span) slot = 0;
         pos_q = POS_W'(slot);
      end
      r.seeking     = seek_q;
      r.data_end    = end_q;
      r.seek_failed = failed;
      return r;
   endfunction

   function automatic void feed(input logic [BYTE_W-1:0] b);
      byte_feed_q.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void feed_tag();
      feed(DATA_TAG[31:24]);
      feed(DATA_TAG[23:16]);
      feed(DATA_TAG[15:8]);
      feed(DATA_TAG[7:0]);
   endfunction

   function automatic int idle_level();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 45;
      endcase
   endfunction

   task automatic flag_mismatch(input string field, input logic [END_W-1:0] got,
                                input logic [END_W-1:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] %s: got %h, want %h (result %0d)", $time, field, got, want,
                  results_seen);
      mismatch_count++;
   endtask

   // Register write; only called while no item is in flight, so the predictor
   // copy can be updated right away. Bits above a narrow register get noise.
   task automatic write_reg(input csr_index_type idx, input logic [END_W-1:0] value);
      logic [END_W-1:0] word;
      word = value;
      case (idx)
         CSR_FRAME_BYTES: begin
            word[END_W-1:STRIDE_W] = (END_W-STRIDE_W)'($urandom());
            cfg_frame_bytes = value[STRIDE_W-1:0];
            stride_q        = cfg_frame_bytes;
            pos_q           = '0;           // a stride write restarts the frame
         end
         CSR_DECODE_MODE: begin
            word[END_W-1:1] = (END_W-1)'($urandom());
            cfg_decode      = value[0];
         end
         CSR_START_SEEKING: begin
            word[END_W-1:1] = (END_W-1)'($urandom());
            cfg_start_seek  = value[0];
            seek_q          = value[0];     // resumes with the current window
         end
         CSR_INITIAL_DATA_END: begin
            cfg_initial_end = value;
            end_q           = value;
         end
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Every item yields exactly one result, so the block is idle once the counts meet.
   task automatic wait_drained();
      do @(negedge clock); while (results_seen != bytes_queued);
      repeat (2) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: presents queued items, with random idle bursts between them
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(IDLE_MAX - 1);  // this cycle is the first idle one
            req_valid <= 1'b0;
         end else if (byte_feed_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_in_byte <= byte_feed_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, same burst scheme
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
         recv_stall = $urandom_range(IDLE_MAX - 1);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted item, check every accepted result
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            coded_rsp_q.push_back(filter_byte(req_in_byte));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (coded_rsp_q.size() == 0) begin
               flag_mismatch("result with none expected", END_W'(rsp_out_byte), '0);
            end else begin
               head_rsp = coded_rsp_q.pop_front();
               if (rsp_out_byte !== head_rsp.out_byte)
                  flag_mismatch("out_byte", END_W'(rsp_out_byte),
                                END_W'(head_rsp.out_byte));
               if (rsp_seeking !== head_rsp.seeking)
                  flag_mismatch("seeking", END_W'(rsp_seeking), END_W'(head_rsp.seeking));
               if (rsp_data_end !== head_rsp.data_end)
                  flag_mismatch("data_end", rsp_data_end, head_rsp.data_end);
               if (rsp_seek_failed !== head_rsp.seek_failed)
                  flag_mismatch("seek_failed", END_W'(rsp_seek_failed),
                                END_W'(head_rsp.seek_failed));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results seen", cycle_count,
                  results_seen, bytes_queued);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      int                phase;
      int                n;
      int                k;
      int                pick;
      logic [END_W-1:0]  len;
      logic [BYTE_W-1:0] level;

      // predictor reset values match the block's register reset values
      cfg_frame_bytes = STRIDE_W'(1);
      cfg_decode      = 1'b0;
      cfg_start_seek  = 1'b0;
      cfg_initial_end = '0;
      foreach (hist_q[i]) hist_q[i] = '0;
      pos_q    = '0;
      stride_q = cfg_frame_bytes;
      window_q = '0;
      left_q   = '0;
      seek_q   = cfg_start_seek;
      end_q    = cfg_initial_end;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // reset settings: stride 1, encode, no seek
      feed(8'h00);
      feed(8'hFF);
      feed(8'h80);
      wait_drained();

      // zero stride behaves as 1; decode adds back; most negative data end
      write_reg(CSR_FRAME_BYTES, 0);
      write_reg(CSR_DECODE_MODE, 1);
      write_reg(CSR_INITIAL_DATA_END, 32'h8000_0000);
      feed(8'hFF);
      feed(8'h01);
      wait_drained();

      // largest field value, well past the history depth: clamped
      write_reg(CSR_FRAME_BYTES, 63);
      write_reg(CSR_DECODE_MODE, 0);
      feed(8'h7F);
      feed(8'hFE);
      wait_drained();

      // clean seek: tag, then length 16 below the largest data end
      write_reg(CSR_INITIAL_DATA_END, 32'h7FFF_FFFF);
      write_reg(CSR_START_SEEKING, 1);
      feed_tag();
      feed(8'h10);
      feed(8'h00);
      feed(8'h00);
      feed(8'h00);
      feed(8'hAA);
      feed(8'h55);
      wait_drained();

      // reseek from the delta phase; the length bytes spell the tag again (no
      // re-arm) and that length is not below 16, so the capture fails
      write_reg(CSR_START_SEEKING, 1);
      feed_tag();
      feed_tag();
      wait_drained();

      // ---- random part ----
      for (phase = 0; phase < PHASES; phase++) begin
         // a random subset of registers per phase; untouched ones keep their state
         if (phase == 0 || $urandom_range(2) == 0) begin
            pick = $urandom_range(9);
            if (pick == 0)      write_reg(CSR_FRAME_BYTES, 0);
            else if (pick == 1) write_reg(CSR_FRAME_BYTES, FRAME_CAP);
            else if (pick == 2) write_reg(CSR_FRAME_BYTES, $urandom_range(FRAME_CAP + 1, 63));
            else if (pick == 3) write_reg(CSR_FRAME_BYTES, $urandom_range(9, FRAME_CAP - 1));
            else                write_reg(CSR_FRAME_BYTES, $urandom_range(1, 8));
         end
         if ($urandom_range(1) == 0)
            write_reg(CSR_DECODE_MODE, $urandom_range(1));
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(5))
               0, 1:    len = 32'h7FFF_FFFF;
               2:       len = 32'h8000_0000;
               3:       len = '0;
               4:       len = $urandom_range(1000, 1000000);
               default: len = $urandom();
            endcase
            write_reg(CSR_INITIAL_DATA_END, len);
         end
         if ($urandom_range(4) != 0)      write_reg(CSR_START_SEEKING, 1);
         else if ($urandom_range(1) == 0) write_reg(CSR_START_SEEKING, 0);

         if (phase >= QUIET_PHASE) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = idle_level();
            recv_idle_pct = idle_level();
         end

         if (seek_q) begin
            // header noise, sometimes a torn tag, then mostly a full tag and length
            n = $urandom_range(5);
            for (k = 0; k < n; k++) feed(BYTE_W'($urandom()));
            if ($urandom_range(3) == 0) begin
               feed(DATA_TAG[31:24]);
               feed(DATA_TAG[23:16]);
            end
            if ($urandom_range(7) != 0) begin
               feed_tag();
               pick = $urandom_range(7);
               if (pick == 0)
                  len = end_q;                 // equal to data end: fails
               else if (pick == 1)
                  len = end_q - 1;             // just below
               else if (pick == 2 || end_q < -32'sd2147000000)
                  len = $urandom();
               else
                  len = end_q - $urandom_range(1, 65536);
               // now and then the length is cut short and the next phase finishes it
               n = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
               for (k = 0; k < n; k++) feed(len[8*k +: 8]);
            end
         end

         // payload: a mix of smooth runs and jumps
         n     = $urandom_range(14, 32);
         level = BYTE_W'($urandom());
         for (k = 0; k < n; k++) begin
            if ($urandom_range(2) == 0) level = BYTE_W'($urandom());
            else level = level + BYTE_W'($urandom_range(6)) - BYTE_W'(3);
            feed(level);
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (coded_rsp_q.size() != 0)
         flag_mismatch("results never delivered", coded_rsp_q.size(), '0);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
